// ----- design/lwb_pkg.sv -----
// shared types and constants for the wave-and-breath pixel pattern
package lwb_pkg;

  // field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PIX_IDX_W = 6;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned GRB_W     = 3 * CH_W;
  localparam int unsigned ANG_W     = 32;
  localparam int unsigned SINE_W    = 16;
  localparam int unsigned WAVE_W    = 16;
  localparam int unsigned BRIGHT_W  = 17;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_RED   = 2'd0,
    REG_BASE_GREEN = 2'd1,
    REG_BASE_BLUE  = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_e;

  // base colour after reset
  localparam logic [CH_W-1:0] RST_RED   = 8'd255;
  localparam logic [CH_W-1:0] RST_GREEN = 8'd105;
  localparam logic [CH_W-1:0] RST_BLUE  = 8'd180;

  // phase rates in turns per ms, scaled by 2^48, split into 20-bit low and 19-bit high parts for the time products
  localparam logic [38:0] KW48    = 39'd358385071200;
  localparam logic [38:0] KB48    = 39'd134394401700;
  localparam logic [19:0] KW_LO   = KW48[19:0];
  localparam logic [18:0] KW_HI   = KW48[38:20];
  localparam logic [19:0] KB_LO   = KB48[19:0];
  localparam logic [18:0] KB_HI   = KB48[38:20];
  // per-pixel phase step in turns scaled by 2^32
  localparam logic [29:0] PIX_STEP = 30'd546852220;

  // wave = 0.65 + 0.3 s, breath = 0.8 + 0.2 s, offsets in Q0.16 times 2^15
  localparam logic signed [31:0] WAVE_OFS   = 32'sd1395851264;
  localparam logic signed [31:0] WAVE_GAIN  = 32'sd19661;
  localparam logic signed [31:0] BRTH_OFS   = 32'sd1717993472;
  localparam logic signed [31:0] BRTH_GAIN  = 32'sd13107;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 17'd65536;

  // sideband that travels with each pixel word
  typedef struct packed {
    logic                 vld;
    logic                 on;
    logic                 last;
    logic [PIX_IDX_W-1:0] idx;
  } lwb_tag_t;

endpackage

// ----- design/lwb_phase.sv -----
// phase stages: time products, exact 48-bit reduction and per-pixel wave angle
module lwb_phase import lwb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lwb_tag_t         tag_i,
  input  logic [TIME_W-1:0] time_i,
  output lwb_tag_t         tag_o,
  output logic [ANG_W-1:0] wave_ang_o,
  output logic [ANG_W-1:0] breath_ang_o
);

  lwb_tag_t    tag1_q, tag2_q, tag3_q;
  logic [51:0] wlo_d, wlo_q, blo_d, blo_q;
  logic [50:0] whi_full, bhi_full;
  logic [27:0] whi_q, bhi_q;
  logic [35:0] pix_full;
  logic [31:0] pix1_q, pix2_q;
  logic [47:0] wsum, bsum;
  logic [31:0] wbase_q, bang2_q, wang_q, bang3_q;

  // stage 1: partial products of time by the two rates, pixel offset
  always_comb begin
    wlo_d    = 52'(time_i) * 52'(KW_LO);
    blo_d    = 52'(time_i) * 52'(KB_LO);
    whi_full = 51'(time_i) * 51'(KW_HI);
    bhi_full = 51'(time_i) * 51'(KB_HI);
    pix_full = 36'(tag_i.idx) * 36'(PIX_STEP);
  end

  // stage 2: sum modulo 2^48, angle is the top 32 bits
  always_comb begin
    wsum = wlo_q[47:0] + {whi_q, 20'b0};
    bsum = blo_q[47:0] + {bhi_q, 20'b0};
  end

  // control side of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // data side of the stages
  always_ff @(posedge clk_i) begin
    wlo_q   <= wlo_d;
    blo_q   <= blo_d;
    whi_q   <= whi_full[27:0];
    bhi_q   <= bhi_full[27:0];
    pix1_q  <= pix_full[31:0];
    wbase_q <= wsum[47:16];
    bang2_q <= bsum[47:16];
    pix2_q  <= pix1_q;
    wang_q  <= wbase_q + pix2_q;
    bang3_q <= bang2_q;
  end

  assign tag_o        = tag3_q;
  assign wave_ang_o   = wang_q;
  assign breath_ang_o = bang3_q;

endmodule

// ----- design/lwb_sine_rom.sv -----
// sine lookup: table index from angle, then a two-port registered rom read
module lwb_sine_rom import lwb_pkg::*; #(
  parameter int unsigned SineTableDepth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lwb_tag_t                 tag_i,
  input  logic [ANG_W-1:0]         wave_ang_i,
  input  logic [ANG_W-1:0]         breath_ang_i,
  output lwb_tag_t                 tag_o,
  output logic signed [SINE_W-1:0] wave_sin_o,
  output logic signed [SINE_W-1:0] breath_sin_o
);

  localparam int unsigned IW = $clog2(SineTableDepth);
  localparam int unsigned DW = IW + 1;
  localparam int unsigned PW = ANG_W + DW;
  localparam logic [DW-1:0] DEPTH_V = DW'(SineTableDepth);

  typedef logic signed [SINE_W-1:0] rom_t [SineTableDepth];

  // sin(pi/2 u) on a folded quarter wave, u and result in Q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2, p;
    u2 = (u * u) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((p * u2) >> 30);
    p  = 64'd85569305 - ((p * u2) >> 30);
    p  = 64'd693598669 - ((p * u2) >> 30);
    p  = 64'd1686629713 - ((p * u2) >> 30);
    return (p * u) >> 30;
  endfunction

  // table contents worked out at elaboration, Q1.15 entries
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] a, q, r, u, s, v;
    for (int k = 0; k < SineTableDepth; k++) begin
      a = (64'(k) << 32) / SineTableDepth;
      q = a >> 30;
      r = a & 64'h3FFF_FFFF;
      u = q[0] ? (64'd1073741824 - r) : r;
      s = quarter_sine(u);
      if (s > 64'd1073741824) begin
        s = 64'd1073741824;
      end
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      rom[k] = (q >= 64'd2) ? -SINE_W'(v) : SINE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  lwb_tag_t                 tag4_q, tag5_q;
  logic [PW-1:0]            wprod, bprod;
  logic [IW-1:0]            widx_q, bidx_q;
  logic signed [SINE_W-1:0] ws_q, bs_q;

  // index = floor(angle * depth / 2^32)
  always_comb begin
    wprod = PW'(wave_ang_i) * PW'(DEPTH_V);
    bprod = PW'(breath_ang_i) * PW'(DEPTH_V);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag4_q <= '0;
      tag5_q <= '0;
    end else begin
      tag4_q <= tag_i;
      tag5_q <= tag4_q;
    end
  end

  // index register then rom read
  always_ff @(posedge clk_i) begin
    widx_q <= wprod[ANG_W +: IW];
    bidx_q <= bprod[ANG_W +: IW];
    ws_q   <= SINE_ROM[widx_q];
    bs_q   <= SINE_ROM[bidx_q];
  end

  assign tag_o        = tag5_q;
  assign wave_sin_o   = ws_q;
  assign breath_sin_o = bs_q;

endmodule

// ----- design/lwb_shade.sv -----
// shading stages: wave and breath levels, brightness, colour scaling
module lwb_shade import lwb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lwb_tag_t                 tag_i,
  input  logic signed [SINE_W-1:0] wave_sin_i,
  input  logic signed [SINE_W-1:0] breath_sin_i,
  input  logic [CH_W-1:0]          base_red_i,
  input  logic [CH_W-1:0]          base_green_i,
  input  logic [CH_W-1:0]          base_blue_i,
  output logic                     pixel_valid_o,
  output logic [GRB_W-1:0]         pixel_grb_o,
  output logic [PIX_IDX_W-1:0]     pixel_index_o,
  output logic                     last_pixel_o
);

  lwb_tag_t             tag6_q, tag7_q, tag8_q;
  logic signed [31:0]   wsum, bsum;
  logic [WAVE_W-1:0]    wave_q;
  logic [BRIGHT_W-1:0]  breath_q, bright_d, bright_q;
  logic [32:0]          bprod;
  logic [24:0]          rprod, gprod, blprod;
  logic [GRB_W-1:0]     grb_d, grb_q;

  // stage 6: wave level in Q0.16, breath level in Q1.16, both sums stay positive
  always_comb begin
    wsum = WAVE_OFS + WAVE_GAIN * 32'(wave_sin_i);
    bsum = BRTH_OFS + BRTH_GAIN * 32'(breath_sin_i);
  end

  // stage 7: brightness product with clamp to one
  always_comb begin
    bprod    = 33'(wave_q) * 33'(breath_q);
    bright_d = (bprod[32:16] > BRIGHT_MAX) ? BRIGHT_MAX : bprod[32:16];
  end

  // stage 8: per-channel scaling, truncating, dark when off
  always_comb begin
    rprod  = 25'(base_red_i) * 25'(bright_q);
    gprod  = 25'(base_green_i) * 25'(bright_q);
    blprod = 25'(base_blue_i) * 25'(bright_q);
    grb_d  = tag7_q.on ? {gprod[23:16], rprod[23:16], blprod[23:16]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag6_q <= '0;
      tag7_q <= '0;
      tag8_q <= '0;
    end else begin
      tag6_q <= tag_i;
      tag7_q <= tag6_q;
      tag8_q <= tag7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wave_q   <= wsum[30:15];
    breath_q <= bsum[31:15];
    bright_q <= bright_d;
    grb_q    <= grb_d;
  end

  assign pixel_valid_o = tag8_q.vld;
  assign pixel_grb_o   = grb_q;
  assign pixel_index_o = tag8_q.idx;
  assign last_pixel_o  = tag8_q.last;

endmodule

// ----- design/led_wave_breath_pattern.sv -----
// top level: frame sequencer, colour registers and the pixel pipeline
// a taken start reaches the outputs via the sequencer, phase, sine and shade registers
// throughput: one pixel word per cycle while a frame is active
// busy drops while the last pixel of a frame is issued, so frames can run back to back
// the result side cannot stall; each word shows for one cycle under pixel_valid_o
// reset clears the pipeline valid bits and loads the default base colour
module led_wave_breath_pattern import lwb_pkg::*; #(
  parameter int unsigned PixelCount     = 14,
  parameter int unsigned SineTableDepth = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [TIME_W-1:0]    time_ms_i,
  input  logic                 lights_enable_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CH_W-1:0]      cfg_wdata_i,
  output logic                 pixel_valid_o,
  output logic [GRB_W-1:0]     pixel_grb_o,
  output logic [PIX_IDX_W-1:0] pixel_index_o,
  output logic                 last_pixel_o
);

  localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(PixelCount - 1);

  logic                 act_d, act_q;
  logic                 on_d, on_q;
  logic [PIX_IDX_W-1:0] idx_d, idx_q;
  logic [TIME_W-1:0]    time_d, time_q;
  logic                 take;
  logic [CH_W-1:0]      red_q, green_q, blue_q;
  lwb_tag_t             tag0, tag_ph, tag_sn;
  logic [ANG_W-1:0]     wave_ang, breath_ang;
  logic signed [SINE_W-1:0] wave_sin, breath_sin;

  // frame sequencer: one pixel issued per cycle while a frame is active
  assign busy_o = act_q && (idx_q != LAST_IDX);
  assign take   = start_i && !busy_o;

  always_comb begin
    act_d  = act_q;
    idx_d  = idx_q;
    on_d   = on_q;
    time_d = time_q;
    if (take) begin
      act_d  = 1'b1;
      idx_d  = '0;
      on_d   = lights_enable_i;
      time_d = time_ms_i;
    end else if (act_q) begin
      if (idx_q == LAST_IDX) begin
        act_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
      on_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      idx_q <= idx_d;
      on_q  <= on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  // colour registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= RST_RED;
      green_q <= RST_GREEN;
      blue_q  <= RST_BLUE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_RED:   red_q   <= cfg_wdata_i;
        REG_BASE_GREEN: green_q <= cfg_wdata_i;
        REG_BASE_BLUE:  blue_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sideband for the issued pixel
  always_comb begin
    tag0.vld  = act_q;
    tag0.on   = on_q;
    tag0.last = (idx_q == LAST_IDX);
    tag0.idx  = idx_q;
  end

  lwb_phase u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag0),
    .time_i       (time_q),
    .tag_o        (tag_ph),
    .wave_ang_o   (wave_ang),
    .breath_ang_o (breath_ang)
  );

  lwb_sine_rom #(
    .SineTableDepth (SineTableDepth)
  ) u_sine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag_ph),
    .wave_ang_i   (wave_ang),
    .breath_ang_i (breath_ang),
    .tag_o        (tag_sn),
    .wave_sin_o   (wave_sin),
    .breath_sin_o (breath_sin)
  );

  lwb_shade u_shade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (tag_sn),
    .wave_sin_i    (wave_sin),
    .breath_sin_i  (breath_sin),
    .base_red_i    (red_q),
    .base_green_i  (green_q),
    .base_blue_i   (blue_q),
    .pixel_valid_o (pixel_valid_o),
    .pixel_grb_o   (pixel_grb_o),
    .pixel_index_o (pixel_index_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ----- design/lwb_checker.sv -----
// port-level checks for the pattern block, bound to the top level
module lwb_checker import lwb_pkg::*; #(
  parameter int unsigned PixelCount = 14
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 pixel_valid_o,
  input logic [PIX_IDX_W-1:0] pixel_index_o,
  input logic                 last_pixel_o
);

  localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(PixelCount - 1);

  // busy only follows a taken frame or earlier busy
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> $past(busy_o || start_i))
    else $error("busy without a frame in flight");

  // a taken frame shows pixel zero after the pipeline depth
  a_frame_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##9 (pixel_valid_o && (pixel_index_o == '0)))
    else $error("first pixel word not at expected latency");

  // words of a frame come in consecutive cycles and order
  a_pixel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && !last_pixel_o) |=>
      (pixel_valid_o && (pixel_index_o == PIX_IDX_W'($past(pixel_index_o) + 1'b1))))
    else $error("pixel words out of order");

  // last flag marks exactly the final index
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> (last_pixel_o == (pixel_index_o == LAST_IDX)))
    else $error("last flag mismatch");

endmodule

bind led_wave_breath_pattern lwb_checker #(.PixelCount(PixelCount)) u_lwb_checker (.*);
